>>> hw/rtl/sbao_pkg.sv
// ----------------------------------------------------------------------------
// sbao_pkg
// Shared constants, types and helpers for the bilinear sample and over blend.
// ----------------------------------------------------------------------------
package sbao_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int REG_W         = 12;
  localparam int IDX_W         = 2;
  localparam logic [REG_W-1:0] DEFAULT_BAND = 12'd8;

  // divider: one entry stage plus one stage per quotient bit
  localparam int QUOT_W   = 8;
  localparam int NUM_W    = 17;
  localparam int DIV_LAT  = QUOT_W + 1;
  // six front stages, divider, output register
  localparam int PIPE_LAT = 6 + DIV_LAT + 1;

  typedef enum logic [IDX_W-1:0] {
    CFG_FRAC_X    = 2'd0,
    CFG_FRAC_Y    = 2'd1,
    CFG_SNAP_BAND = 2'd2
  } cfg_idx_e;

  // x / 255 for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'({8'd0, x[15:8]}) + 17'd1;
    return t[15:8];
  endfunction

endpackage

>>> hw/rtl/sbao_div.sv
// ----------------------------------------------------------------------------
// sbao_div
// Pipelined restoring divider, one quotient bit per stage, saturates at 255.
// ----------------------------------------------------------------------------
module sbao_div (
  input  logic                           clk_i,
  input  logic [sbao_pkg::NUM_W-1:0]     num_i,
  input  logic [sbao_pkg::QUOT_W-1:0]    den_i,
  output logic [sbao_pkg::QUOT_W-1:0]    quot_o
);

  localparam int NW = sbao_pkg::NUM_W;
  localparam int QW = sbao_pkg::QUOT_W;

  logic [NW-1:0] rem_q [QW+1];
  logic [QW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          sat_q [QW+1];

  // entry stage: quotient above 255 is clamped
  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    sat_q[0] <= (num_i >= (NW'(den_i) << QW));
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [NW-1:0] sub;
    logic          take;
    assign sub  = NW'(den_q[k]) << B;
    assign take = rem_q[k] >= sub;
    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= take ? (rem_q[k] - sub) : rem_q[k];
      den_q[k+1] <= den_q[k];
      sat_q[k+1] <= sat_q[k];
      quo_q[k+1] <= quo_q[k] | (take ? (QW'(1) << B) : '0);
    end
  end

  assign quot_o = sat_q[QW] ? {QW{1'b1}} : quo_q[QW];

endmodule

>>> hw/rtl/subpixel_bilinear_alpha_over_top.sv
// ----------------------------------------------------------------------------
// subpixel_bilinear_alpha_over_top
// Bilinear 2x2 RGBA sample with snap band, then straight-alpha over blend.
// ----------------------------------------------------------------------------
// result_valid_o follows start through the front stages, the divider and the output register
// throughput: one pixel per cycle, busy stays low, no stall path
// the per-channel divide by result alpha is a 9-stage pipelined divider
// reset clears valid bits and loads frac_x = 0, frac_y = 0, snap_band = 8
// the receiver cannot stall: each result is shown for one cycle only
module subpixel_bilinear_alpha_over_top #(
  parameter int FRAC_BITS = sbao_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   tap_top_left_i,
  input  logic [31:0]                   tap_top_right_i,
  input  logic [31:0]                   tap_bottom_left_i,
  input  logic [31:0]                   tap_bottom_right_i,
  input  logic [31:0]                   dest_pixel_i,
  output logic                          result_valid_o,
  output logic [31:0]                   blended_pixel_o,
  output logic                          write_enable_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sbao_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [sbao_pkg::REG_W-1:0]    cfg_data_i
);

  localparam int RW = sbao_pkg::REG_W;
  localparam int FW = FRAC_BITS + 1;
  localparam int WW = 2 * FW;
  localparam int PW = WW + 8;
  localparam int AW = PW + 2;
  localparam int CW = (FRAC_BITS > RW ? FRAC_BITS : RW) + 2;
  localparam int NW = sbao_pkg::NUM_W;
  localparam int DL = sbao_pkg::DIV_LAT;
  localparam logic [FW-1:0] ONE  = FW'(1) << FRAC_BITS;
  localparam logic [AW-1:0] HALF = AW'(1) << (2 * FRAC_BITS - 1);

  typedef struct packed {
    logic [31:0] smp;
    logic [31:0] dst;
    logic [7:0]  oa;
  } side_t;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  logic [RW-1:0] frac_x_q, frac_y_q, band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_x_q <= '0;
      frac_y_q <= '0;
      band_q   <= sbao_pkg::DEFAULT_BAND;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (sbao_pkg::cfg_idx_e'(cfg_index_i))
        sbao_pkg::CFG_FRAC_X:    frac_x_q <= cfg_data_i;
        sbao_pkg::CFG_FRAC_Y:    frac_y_q <= cfg_data_i;
        sbao_pkg::CFG_SNAP_BAND: band_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // weights and snap decision from configuration
  logic [FRAC_BITS-1:0] fx, fy;
  logic [FW-1:0]        ofx, ofy;
  logic [RW-1:0]        band;
  logic                 snap_x, snap_y;
  logic [WW-1:0]        w_d [4];

  always_comb begin
    fx     = FRAC_BITS'(frac_x_q);
    fy     = FRAC_BITS'(frac_y_q);
    ofx    = ONE - FW'(fx);
    ofy    = ONE - FW'(fy);
    band   = (band_q == '0) ? sbao_pkg::DEFAULT_BAND : band_q;
    snap_x = (CW'(fx) < CW'(band)) || ((CW'(fx) + CW'(band)) > CW'(ONE));
    snap_y = (CW'(fy) < CW'(band)) || ((CW'(fy) + CW'(band)) > CW'(ONE));
    w_d[0] = WW'(ofx) * WW'(ofy);
    w_d[1] = WW'(fx) * WW'(ofy);
    w_d[2] = WW'(ofx) * WW'(fy);
    w_d[3] = WW'(fx) * WW'(fy);
  end

  // stage 1: capture transaction
  logic          v1_q;
  logic [31:0]   tap1_q [4];
  logic [31:0]   dst1_q;
  logic [WW-1:0] w1_q [4];
  logic          snap1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    tap1_q[0] <= tap_top_left_i;
    tap1_q[1] <= tap_top_right_i;
    tap1_q[2] <= tap_bottom_left_i;
    tap1_q[3] <= tap_bottom_right_i;
    dst1_q    <= dest_pixel_i;
    w1_q      <= w_d;
    snap1_q   <= snap_x && snap_y;
  end

  // stage 2: tap times weight, per channel
  logic          v2_q;
  logic [PW-1:0] prod_d [4][4];
  logic [PW-1:0] prod2_q [4][4];
  logic [31:0]   t00_2_q, dst2_q;
  logic          snap2_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        prod_d[c][t] = PW'(tap1_q[t][8*c +: 8]) * PW'(w1_q[t]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    prod2_q <= prod_d;
    t00_2_q <= tap1_q[0];
    dst2_q  <= dst1_q;
    snap2_q <= snap1_q;
  end

  // stage 3: sum, round half up, clamp, snap select
  logic          v3_q;
  logic [31:0]   smp_d, smp3_q, dst3_q;
  logic [AW-1:0] acc [4];
  logic [AW-2*FRAC_BITS-1:0] rnd [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc[c] = AW'(prod2_q[c][0]) + AW'(prod2_q[c][1]) + AW'(prod2_q[c][2])
             + AW'(prod2_q[c][3]) + HALF;
      rnd[c] = acc[c][AW-1:2*FRAC_BITS];
      smp_d[8*c +: 8] = (rnd[c] > 255) ? 8'hFF : rnd[c][7:0];
    end
    if (snap2_q) smp_d = t00_2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    smp3_q <= smp_d;
    dst3_q <= dst2_q;
  end

  // stage 4: da * (255 - sa)
  logic        v4_q;
  logic [31:0] smp4_q, dst4_q;
  logic [15:0] dinv4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    smp4_q  <= smp3_q;
    dst4_q  <= dst3_q;
    dinv4_q <= 16'(dst3_q[31:24]) * 16'(8'hFF - smp3_q[31:24]);
  end

  // stage 5: result alpha and destination weight
  logic        v5_q;
  logic [31:0] smp5_q, dst5_q;
  logic [7:0]  oa5_q, dw5_q;
  logic [8:0]  oa_sum;

  assign oa_sum = 9'(smp4_q[31:24]) + 9'(sbao_pkg::div255(dinv4_q + 16'd127));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    smp5_q <= smp4_q;
    dst5_q <= dst4_q;
    oa5_q  <= oa_sum[7:0];
    dw5_q  <= sbao_pkg::div255(dinv4_q);
  end

  // stage 6: blend numerators
  logic          v6_q;
  logic [NW-1:0] num6_q [3];
  side_t         side6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else         v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      num6_q[c] <= NW'(smp5_q[8*c +: 8]) * NW'(smp5_q[31:24])
                 + NW'(dst5_q[8*c +: 8]) * NW'(dw5_q)
                 + NW'(oa5_q[7:1]);
    end
    side6_q <= '{smp: smp5_q, dst: dst5_q, oa: oa5_q};
  end

  // divide by result alpha, side band travels alongside
  logic [7:0] quot [3];

  for (genvar c = 0; c < 3; c++) begin : g_div
    sbao_div u_div (
      .clk_i  (clk_i),
      .num_i  (num6_q[c]),
      .den_i  (side6_q.oa),
      .quot_o (quot[c])
    );
  end

  side_t side_q [DL];
  logic  vd_q   [DL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DL; i++) vd_q[i] <= 1'b0;
    end else begin
      vd_q[0] <= v6_q;
      for (int i = 1; i < DL; i++) vd_q[i] <= vd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side6_q;
    for (int i = 1; i < DL; i++) side_q[i] <= side_q[i-1];
  end

  // output stage: special cases
  side_t       sd;
  logic [31:0] res_d;
  logic        we_d;

  always_comb begin
    sd   = side_q[DL-1];
    we_d = 1'b1;
    if (sd.smp[31:24] == 8'h00) begin
      res_d = sd.dst;
      we_d  = 1'b0;
    end else if (sd.smp[31:24] == 8'hFF) begin
      res_d = {8'hFF, sd.smp[23:0]};
    end else if (sd.oa == 8'h00) begin
      res_d = '0;
    end else begin
      res_d = {sd.oa, quot[2], quot[1], quot[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
      write_enable_o <= 1'b0;
    end else begin
      result_valid_o <= vd_q[DL-1];
      write_enable_o <= vd_q[DL-1] && we_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blended_pixel_o <= res_d;
  end

endmodule

>>> hw/rtl/sbao_checker.sv
// ----------------------------------------------------------------------------
// sbao_checker
// Port-level checks on the result strobe, write enable, latency and busy.
// ----------------------------------------------------------------------------
module sbao_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic        write_enable_o,
  input logic [31:0] blended_pixel_o
);

  // write enable only rides on a result
  a_we_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> !write_enable_o)
    else $error("write enable without result");

  // a written pixel always has nonzero alpha
  a_we_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && write_enable_o) |-> (blended_pixel_o[31:24] != 8'h00))
    else $error("written pixel with zero alpha");

  // every result traces back to an accepted transaction at fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, sbao_pkg::PIPE_LAT))
    else $error("result without matching transaction");

  // the block never pushes back
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(start) |-> !busy)
    else $error("busy asserted");

endmodule

bind subpixel_bilinear_alpha_over_top sbao_checker u_sbao_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_valid_o  (result_valid_o),
  .write_enable_o  (write_enable_o),
  .blended_pixel_o (blended_pixel_o)
);
